[rtl/at_modem_response_parser_assert.svh]
// Assertion macros shared by the modem response parser modules.
`ifndef AT_MODEM_RESPONSE_PARSER_ASSERT_SVH
`define AT_MODEM_RESPONSE_PARSER_ASSERT_SVH

// Same-cycle implication under the asynchronous reset.
`define AMRP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("at_modem_response_parser: same-cycle check failed");

// Next-cycle implication under the asynchronous reset.
`define AMRP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("at_modem_response_parser: next-cycle check failed");

`endif

[rtl/amrp_pkg.sv]
// Types and constants shared by the modem response parser modules.
package amrp_pkg;

	localparam int CharW     = 8;
	localparam int LenW      = 8;
	localparam int PayLenW   = 12;
	localparam int LinkMaskW = 5;
	localparam int LinkW     = 3;
	localparam int HeadW     = 4 * CharW;
	localparam int TailW     = 11 * CharW;

	localparam logic CmdByte = 1'b0;
	localparam logic CmdSend = 1'b1;

	localparam logic [CharW-1:0] CharNl     = 8'h0A;
	localparam logic [CharW-1:0] CharCr     = 8'h0D;
	localparam logic [CharW-1:0] CharPrompt = 8'h3E;
	localparam logic [CharW-1:0] CharColon  = 8'h3A;
	localparam logic [CharW-1:0] CharComma  = 8'h2C;
	localparam logic [CharW-1:0] CharSpace  = 8'h20;
	localparam logic [CharW-1:0] Char0      = 8'h30;
	localparam logic [CharW-1:0] Char9      = 8'h39;

	localparam logic [31:0] StrIpd      = "+IPD";
	localparam logic [31:0] StrRecv     = "Recv";
	localparam logic [23:0] StrId       = "id:";
	localparam logic [31:0] StrOk       = {"OK", CharCr, CharNl};
	localparam logic [15:0] StrCrNl     = {CharCr, CharNl};
	localparam logic [23:0] StrSpCrNl   = {CharSpace, CharCr, CharNl};
	localparam logic [47:0] StrAte0     = {"ATE0", CharCr, CharNl};
	localparam logic [55:0] StrReady    = {"ready", CharCr, CharNl};
	localparam logic [55:0] StrError    = {"ERROR", CharCr, CharNl};
	localparam logic [63:0] StrClosed   = {"CLOSED", CharCr, CharNl};
	localparam logic [71:0] StrConnect  = {"CONNECT", CharCr, CharNl};
	localparam logic [71:0] StrSendOk   = {"SEND OK", CharCr, CharNl};
	localparam logic [87:0] StrSendFail = {"SEND FAIL", CharCr, CharNl};

	typedef enum logic [3:0] {
		EV_NONE      = 4'd0,
		EV_OK        = 4'd1,
		EV_ERROR     = 4'd2,
		EV_SEND_OK   = 4'd3,
		EV_SEND_FAIL = 4'd4,
		EV_READY     = 4'd5,
		EV_CONNECT   = 4'd6,
		EV_CLOSED    = 4'd7,
		EV_PROMPT    = 4'd8,
		EV_PAYLOAD   = 4'd9,
		EV_OTHER     = 4'd10,
		EV_OVERFLOW  = 4'd11
	} event_t;

	typedef enum logic [1:0] {
		ST_IDLE    = 2'd0,
		ST_READY   = 2'd1,
		ST_SENDING = 2'd2,
		ST_ERROR   = 2'd3
	} status_t;

	typedef struct packed {
		event_t                 ev;
		logic [LinkW-1:0]       link;
		logic                   pvalid;
		logic [CharW-1:0]       pbyte;
		logic                   plast;
		logic [CharW-1:0]       plink;
		status_t                status;
		logic                   ready;
		logic [LinkMaskW-1:0]   links;
	} res_t;

endpackage

[rtl/amrp_classify.sv]
// Line classifier that matches the head and tail bytes of a finished line.
module amrp_classify (
	input  logic [amrp_pkg::LenW-1:0]  len,
	input  logic [amrp_pkg::HeadW-1:0] head,
	input  logic [amrp_pkg::TailW-1:0] tail,
	output amrp_pkg::event_t           ev
);

	always_comb begin
		priority if (len >= 8'd9 && tail[71:0] == amrp_pkg::StrConnect) begin
			ev = amrp_pkg::EV_CONNECT;
		end else if (len >= 8'd8 && tail[63:0] == amrp_pkg::StrClosed) begin
			ev = amrp_pkg::EV_CLOSED;
		end else if (len >= 8'd4 && head == amrp_pkg::StrRecv) begin
			ev = amrp_pkg::EV_NONE;
		end else if (len >= 8'd3 && head[31:8] == amrp_pkg::StrId) begin
			ev = amrp_pkg::EV_NONE;
		end else begin
			unique case (len)
				8'd1: ev = (tail[7:0] == amrp_pkg::CharNl) ?
					amrp_pkg::EV_NONE : amrp_pkg::EV_OTHER;
				8'd2: ev = (tail[15:0] == amrp_pkg::StrCrNl) ?
					amrp_pkg::EV_NONE : amrp_pkg::EV_OTHER;
				8'd3: ev = (tail[23:0] == amrp_pkg::StrSpCrNl) ?
					amrp_pkg::EV_NONE : amrp_pkg::EV_OTHER;
				8'd4: ev = (head == amrp_pkg::StrOk) ?
					amrp_pkg::EV_OK : amrp_pkg::EV_NONE;
				8'd6: ev = (tail[47:0] == amrp_pkg::StrAte0) ?
					amrp_pkg::EV_NONE : amrp_pkg::EV_OTHER;
				8'd7: begin
					priority if (tail[55:0] == amrp_pkg::StrReady) begin
						ev = amrp_pkg::EV_READY;
					end else if (tail[55:0] == amrp_pkg::StrError) begin
						ev = amrp_pkg::EV_ERROR;
					end else begin
						ev = amrp_pkg::EV_OTHER;
					end
				end
				8'd9: ev = (tail[71:0] == amrp_pkg::StrSendOk) ?
					amrp_pkg::EV_SEND_OK : amrp_pkg::EV_OTHER;
				8'd11: ev = (tail == amrp_pkg::StrSendFail) ?
					amrp_pkg::EV_SEND_FAIL : amrp_pkg::EV_OTHER;
				default: ev = amrp_pkg::EV_OTHER;
			endcase
		end
	end

endmodule

[rtl/amrp_core.sv]
// Parser state and the combinational step logic for one received beat.
`include "at_modem_response_parser_assert.svh"

module amrp_core #(
	parameter int LINE_MAX    = 128,
	parameter int PAYLOAD_MAX = 2048,
	parameter int LINK_COUNT  = 5
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic                       cmd,
	input  logic [amrp_pkg::CharW-1:0] c,
	output amrp_pkg::res_t             res
);

	logic [amrp_pkg::LenW-1:0]      line_length_q, line_length_d, len_n;
	logic [amrp_pkg::HeadW-1:0]     head_q, head_d, head_n;
	logic [amrp_pkg::TailW-1:0]     tail_q, tail_d, tail_n;
	logic [1:0]                     hc_q, hc_d;
	logic [amrp_pkg::CharW-1:0]     hlink_q, hlink_d;
	logic [amrp_pkg::PayLenW-1:0]   hlen_q, hlen_d;
	logic                           in_pay_q, in_pay_d;
	logic [amrp_pkg::PayLenW-1:0]   rem_q, rem_d;
	amrp_pkg::status_t              status_q, status_d;
	logic                           rdy_q, rdy_d;
	logic [amrp_pkg::LinkMaskW-1:0] mask_q, mask_d;
	amrp_pkg::event_t               cls_ev;
	logic                           pay_go, is_ipd, is_digit;
	logic [15:0]                    acc;
	logic [3:0]                     lk_line, lk_hdr;

	function automatic logic [3:0] link_of(input logic [amrp_pkg::CharW-1:0] ch);
		logic [amrp_pkg::CharW-1:0] diff;
		diff = ch - amrp_pkg::Char0;
		return {(ch >= amrp_pkg::Char0) && (diff < 8'(LINK_COUNT)), diff[2:0]};
	endfunction

	always_comb begin
		len_n  = line_length_q + 8'd1;
		tail_n = {tail_q[amrp_pkg::TailW-amrp_pkg::CharW-1:0], c};
		head_n = head_q;
		for (int i = 0; i < 4; i++) begin
			if (line_length_q == 8'(i)) begin
				head_n[amrp_pkg::HeadW-1-8*i -: 8] = c;
			end
		end
	end

	amrp_classify u_classify (
		.len  (len_n),
		.head (head_n),
		.tail (tail_n),
		.ev   (cls_ev)
	);

	assign pay_go   = in_pay_q && (rem_q != '0);
	assign is_ipd   = (line_length_q >= 8'd4) && (head_q == amrp_pkg::StrIpd);
	assign is_digit = (c >= amrp_pkg::Char0) && (c <= amrp_pkg::Char9);
	assign acc      = ({4'b0, hlen_q} << 3) + ({4'b0, hlen_q} << 1)
		+ {8'b0, c - amrp_pkg::Char0};
	assign lk_line  = link_of(head_n[amrp_pkg::HeadW-1 -: 8]);

	always_comb begin
		line_length_d = line_length_q;
		head_d        = head_q;
		tail_d        = tail_q;
		hc_d          = hc_q;
		hlink_d       = hlink_q;
		hlen_d        = hlen_q;
		in_pay_d      = in_pay_q;
		rem_d         = rem_q;
		status_d      = status_q;
		rdy_d         = rdy_q;
		mask_d        = mask_q;
		res           = '0;
		res.ev        = amrp_pkg::EV_NONE;
		lk_hdr        = '0;

		if (cmd == amrp_pkg::CmdSend) begin
			status_d = amrp_pkg::ST_SENDING;
		end else if (pay_go) begin
			res.pvalid = 1'b1;
			res.pbyte  = c;
			res.plink  = hlink_q;
			rem_d      = rem_q - amrp_pkg::PayLenW'(1);
			if (rem_q == amrp_pkg::PayLenW'(1)) begin
				res.plast = 1'b1;
				in_pay_d  = 1'b0;
			end
		end else begin
			in_pay_d      = 1'b0;
			head_d        = head_n;
			tail_d        = tail_n;
			line_length_d = len_n;
			if (is_ipd) begin
				priority if (c == amrp_pkg::CharComma) begin
					if (hc_q != 2'd3) begin
						hc_d = hc_q + 2'd1;
					end
				end else if (hc_q == 2'd1) begin
					hlink_d = c;
				end else if (hc_q == 2'd2 && c != amrp_pkg::CharColon) begin
					if (is_digit) begin
						if (acc > 16'(PAYLOAD_MAX)) begin
							hlen_d = amrp_pkg::PayLenW'(PAYLOAD_MAX);
						end else begin
							hlen_d = acc[amrp_pkg::PayLenW-1:0];
						end
					end else begin
						hc_d = 2'd3;
					end
				end
			end
			lk_hdr = link_of(hlink_d);

			priority if (c == amrp_pkg::CharNl) begin
				res.ev = cls_ev;
				unique case (cls_ev)
					amrp_pkg::EV_OK, amrp_pkg::EV_SEND_OK: status_d = amrp_pkg::ST_READY;
					amrp_pkg::EV_ERROR, amrp_pkg::EV_SEND_FAIL: status_d = amrp_pkg::ST_ERROR;
					amrp_pkg::EV_READY: rdy_d = 1'b1;
					amrp_pkg::EV_CONNECT: begin
						if (lk_line[3]) begin
							res.link = lk_line[2:0];
							mask_d   = mask_q | (amrp_pkg::LinkMaskW'(1) << lk_line[2:0]);
						end
					end
					amrp_pkg::EV_CLOSED: begin
						if (lk_line[3]) begin
							res.link = lk_line[2:0];
							mask_d   = mask_q & ~(amrp_pkg::LinkMaskW'(1) << lk_line[2:0]);
						end
					end
					default: ;
				endcase
				line_length_d = '0;
				hc_d          = '0;
				hlen_d        = '0;
			end else if (c == amrp_pkg::CharPrompt) begin
				res.ev        = amrp_pkg::EV_PROMPT;
				line_length_d = '0;
				hc_d          = '0;
				hlen_d        = '0;
			end else if (c == amrp_pkg::CharColon && is_ipd) begin
				res.ev        = amrp_pkg::EV_PAYLOAD;
				res.link      = lk_hdr[3] ? lk_hdr[2:0] : '0;
				rem_d         = hlen_q;
				in_pay_d      = (hlen_q != '0);
				line_length_d = '0;
				hc_d          = '0;
				hlen_d        = '0;
			end else if (len_n >= 8'(LINE_MAX)) begin
				res.ev        = amrp_pkg::EV_OVERFLOW;
				line_length_d = '0;
				hc_d          = '0;
				hlen_d        = '0;
			end
		end

		res.status = status_d;
		res.ready  = rdy_d;
		res.links  = mask_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q <= '0;
			hc_q          <= '0;
			hlink_q       <= '0;
			hlen_q        <= '0;
			in_pay_q      <= 1'b0;
			rem_q         <= '0;
			status_q      <= amrp_pkg::ST_IDLE;
			rdy_q         <= 1'b0;
			mask_q        <= '0;
		end else if (step) begin
			line_length_q <= line_length_d;
			hc_q          <= hc_d;
			hlink_q       <= hlink_d;
			hlen_q        <= hlen_d;
			in_pay_q      <= in_pay_d;
			rem_q         <= rem_d;
			status_q      <= status_d;
			rdy_q         <= rdy_d;
			mask_q        <= mask_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			head_q <= head_d;
			tail_q <= tail_d;
		end
	end

	`AMRP_ASSERT_IMP(a_pay_count, clk, arst_n, 1'b1, in_pay_q == (rem_q != '0))
	`AMRP_ASSERT_IMP(a_line_range, clk, arst_n, 1'b1, line_length_q < 8'(LINE_MAX))
	`AMRP_ASSERT_IMP(a_len_sat, clk, arst_n, 1'b1, hlen_q <= amrp_pkg::PayLenW'(PAYLOAD_MAX))

endmodule

[rtl/at_modem_response_parser.sv]
// Top level of the modem response parser: input stage, parser core and result register.
//
//   channel  direction  tdata                  tuser                 tlast
//   s_*      in         rx_byte                command               -
//   m_*      out        link, payload, status  event, payload flag   payload last
//
// The parser core steps once per beat, so one beat is accepted per clock while the output is not stalled.
// An accepted beat passes the input stage, then the result register, before it reaches m_tvalid.
// The reset clears both stage valids and the parser state apart from the head and tail byte registers;
// there is no clearing pass. When m_tready is low the result register holds, and s_tready falls only once the
// input stage also holds a beat.
`include "at_modem_response_parser_assert.svh"

module at_modem_response_parser #(
	parameter int LINE_MAX    = 128,
	parameter int PAYLOAD_MAX = 2048,
	parameter int LINK_COUNT  = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] rx_byte
	input  logic        s_tuser,  // [0] command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [2:0] event_link, [10:3] payload_byte,
	                              // [18:11] payload_link, [20:19] modem_status,
	                              // [21] modem_ready, [26:22] links_connected
	output logic [4:0]  m_tuser,  // [3:0] event_res, [4] payload_valid
	output logic        m_tlast   // payload_last
);

	logic                       valid_s1, cmd_s1, valid_s2, out_free, adv;
	logic [amrp_pkg::CharW-1:0] byte_s1;
	amrp_pkg::res_t             res, res_s2;

	assign out_free = !valid_s2 || m_tready;
	assign adv      = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (out_free) begin
				valid_s2 <= adv;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1  <= s_tuser;
			byte_s1 <= s_tdata;
		end
		if (adv) begin
			res_s2 <= res;
		end
	end

	amrp_core #(
		.LINE_MAX    (LINE_MAX),
		.PAYLOAD_MAX (PAYLOAD_MAX),
		.LINK_COUNT  (LINK_COUNT)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.cmd    (cmd_s1),
		.c      (byte_s1),
		.res    (res)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'b0, res_s2.links, res_s2.ready, res_s2.status, res_s2.plink,
		res_s2.pbyte, res_s2.link};
	assign m_tuser  = {res_s2.pvalid, res_s2.ev};
	assign m_tlast  = res_s2.plast;

	`AMRP_ASSERT_NXT(a_adv_out, clk, arst_n, adv, m_tvalid)
	`AMRP_ASSERT_IMP(a_stall_full, clk, arst_n, !s_tready, valid_s1 && valid_s2 && !m_tready)

endmodule

[test/at_modem_response_checker.sv]
// Watches both streams of the modem response parser, predicts every result beat and compares it.
`timescale 1ns / 100ps

module at_modem_response_checker #(
	parameter int LINE_MAX    = 128,
	parameter int PAYLOAD_MAX = 2048,
	parameter int LINK_COUNT  = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] rx_byte
	input  logic        s_tuser,  // [0] command
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,  // [2:0] event_link, [10:3] payload_byte,
	                              // [18:11] payload_link, [20:19] modem_status,
	                              // [21] modem_ready, [26:22] links_connected
	input  logic [4:0]  m_tuser,  // [3:0] event_res, [4] payload_valid
	input  logic        m_tlast,
	output int          failures,
	output int          outstanding
);
	import amrp_pkg::*;

	int               line_len;
	logic [HeadW-1:0] line_head;
	logic [TailW-1:0] line_tail;
	int               hdr_commas;
	logic [7:0]       hdr_link;
	int               hdr_len;
	bit               in_payload;
	int               pay_left;
	status_t          status;
	bit               ready_seen;
	logic [4:0]       link_mask;
	res_t             predicted_events[$];
	res_t             want;
	res_t             got;
	int               mismatches = 0;

	function automatic bit link_valid(input logic [7:0] c);
		return c >= Char0 && int'(c - Char0) < LINK_COUNT;
	endfunction

	function automatic logic [2:0] link_num(input logic [7:0] c);
		return link_valid(c) ? 3'(c - Char0) : 3'd0;
	endfunction

	task automatic classify_line(output event_t ev);
		ev = EV_OTHER;
		if (line_len >= 9 && line_tail[71:0] == StrConnect) begin
			if (link_valid(line_head[31:24]))
				link_mask = link_mask | 5'(1 << link_num(line_head[31:24]));
			ev = EV_CONNECT;
		end else if (line_len >= 8 && line_tail[63:0] == StrClosed) begin
			if (link_valid(line_head[31:24]))
				link_mask = link_mask & ~5'(1 << link_num(line_head[31:24]));
			ev = EV_CLOSED;
		end else if (line_len >= 4 && line_head == StrRecv) begin
			ev = EV_NONE;
		end else if (line_len >= 3 && line_head[31:8] == StrId) begin
			ev = EV_NONE;
		end else begin
			case (line_len)
			1: begin
				if (line_tail[7:0] == CharNl) ev = EV_NONE;
			end
			2: begin
				if (line_tail[15:0] == StrCrNl) ev = EV_NONE;
			end
			3: begin
				if (line_tail[23:0] == StrSpCrNl) ev = EV_NONE;
			end
			4: begin
				if (line_head == StrOk) begin
					status = ST_READY;
					ev = EV_OK;
				end else begin
					ev = EV_NONE;
				end
			end
			6: begin
				if (line_tail[47:0] == StrAte0) ev = EV_NONE;
			end
			7: begin
				if (line_tail[55:0] == StrReady) begin
					ready_seen = 1'b1;
					ev = EV_READY;
				end else if (line_tail[55:0] == StrError) begin
					status = ST_ERROR;
					ev = EV_ERROR;
				end
			end
			9: begin
				if (line_tail[71:0] == StrSendOk) begin
					status = ST_READY;
					ev = EV_SEND_OK;
				end
			end
			11: begin
				if (line_tail[87:0] == StrSendFail) begin
					status = ST_ERROR;
					ev = EV_SEND_FAIL;
				end
			end
			default: ;
			endcase
		end
	endtask

	task automatic predict_beat(input logic cmd, input logic [7:0] c, output res_t r);
		int     idx;
		int     v;
		bit     ipd;
		event_t ev;
		r = '0;
		ev = EV_NONE;
		if (cmd == CmdSend) begin
			status = ST_SENDING;
		end else if (in_payload && pay_left != 0) begin
			r.pvalid = 1'b1;
			r.pbyte = c;
			r.plink = hdr_link;
			pay_left--;
			if (pay_left == 0) begin
				r.plast = 1'b1;
				in_payload = 1'b0;
			end
		end else begin
			idx = line_len;
			in_payload = 1'b0;
			if (idx < 4)
				line_head[31 - 8 * idx -: 8] = c;
			line_tail = {line_tail[TailW-9:0], c};
			line_len = idx + 1;
			ipd = idx >= 4 && line_head == StrIpd;
			if (ipd) begin
				if (c == CharComma) begin
					if (hdr_commas < 3) hdr_commas++;
				end else if (hdr_commas == 1) begin
					hdr_link = c;
				end else if (hdr_commas == 2 && c != CharColon) begin
					if (c >= Char0 && c <= Char9) begin
						v = hdr_len * 10 + int'(c - Char0);
						hdr_len = v > PAYLOAD_MAX ? PAYLOAD_MAX : v;
					end else begin
						hdr_commas = 3;
					end
				end
			end
			if (c == CharNl) begin
				classify_line(ev);
				if (ev == EV_CONNECT || ev == EV_CLOSED)
					r.link = link_num(line_head[31:24]);
			end else if (c == CharPrompt) begin
				ev = EV_PROMPT;
			end else if (c == CharColon && ipd) begin
				ev = EV_PAYLOAD;
				r.link = link_num(hdr_link);
				pay_left = hdr_len;
				in_payload = hdr_len != 0;
			end else if (line_len >= LINE_MAX) begin
				ev = EV_OVERFLOW;
			end
			if (c == CharNl || ev != EV_NONE) begin
				line_len = 0;
				hdr_commas = 0;
				hdr_len = 0;
			end
		end
		r.ev = ev;
		r.status = status;
		r.ready = ready_seen;
		r.links = link_mask;
	endtask

	task automatic check_field(input string name, input logic [7:0] want_v,
			input logic [7:0] got_v);
		if (got_v !== want_v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t ns: %s expected %0d, got %0d", $time, name, want_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_len = 0;
			line_head = '0;
			line_tail = '0;
			hdr_commas = 0;
			hdr_link = '0;
			hdr_len = 0;
			in_payload = 1'b0;
			pay_left = 0;
			status = ST_IDLE;
			ready_seen = 1'b0;
			link_mask = '0;
			predicted_events.delete();
			failures <= 0;
			outstanding <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_beat(s_tuser, s_tdata, want);
				predicted_events.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				if (predicted_events.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t ns: result beat arrived with none predicted", $time);
				end else begin
					want = predicted_events.pop_front();
					got.ev = event_t'(m_tuser[3:0]);
					got.link = m_tdata[2:0];
					got.pvalid = m_tuser[4];
					got.pbyte = m_tdata[10:3];
					got.plast = m_tlast;
					got.plink = m_tdata[18:11];
					got.status = status_t'(m_tdata[20:19]);
					got.ready = m_tdata[21];
					got.links = m_tdata[26:22];
					check_field("event_res", want.ev, got.ev);
					check_field("event_link", want.link, got.link);
					check_field("payload_valid", want.pvalid, got.pvalid);
					check_field("payload_byte", want.pbyte, got.pbyte);
					check_field("payload_last", want.plast, got.plast);
					check_field("payload_link", want.plink, got.plink);
					check_field("modem_status", want.status, got.status);
					check_field("modem_ready", want.ready, got.ready);
					check_field("links_connected", want.links, got.links);
				end
			end
			failures <= mismatches;
			outstanding <= predicted_events.size();
		end
	end

endmodule

[test/testbench.sv]
// Top of the modem response parser test: clock, reset, modem byte traffic and the verdict.
`timescale 1ns / 100ps

module testbench;
	import amrp_pkg::*;

	localparam int LineMax    = 128;
	localparam int PayloadMax = 2048;
	localparam int LinkCount  = 5;
	localparam int Items      = 1700;
	localparam int CycleLimit = 200000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [4:0]  m_tuser;
	logic        m_tlast;
	int          failures;
	int          outstanding;
	int          items_sent = 0;
	int          rx_hold = 0;
	int          cycles;
	bit          calm = 1'b0;

	at_modem_response_parser #(
		.LINE_MAX(LineMax),
		.PAYLOAD_MAX(PayloadMax),
		.LINK_COUNT(LinkCount)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	at_modem_response_checker #(
		.LINE_MAX(LineMax),
		.PAYLOAD_MAX(PayloadMax),
		.LINK_COUNT(LinkCount)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.failures(failures),
		.outstanding(outstanding)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				rx_hold = calm ? 0 : $urandom_range(0, 3);
			else if (rx_hold > 0)
				rx_hold--;
			m_tready <= (rx_hold == 0);
		end
	end

	function automatic logic [7:0] text_char();
		logic [7:0] t;
		t = 8'($urandom_range(32, 126));
		return t == CharPrompt ? 8'h2A : t;
	endfunction

	task automatic push_beat(input logic cmd, input logic [7:0] b);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= cmd;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_text(input string txt, input bit crlf);
		for (int k = 0; k < txt.len(); k++)
			push_beat(CmdByte, txt[k]);
		if (crlf) begin
			push_beat(CmdByte, CharCr);
			push_beat(CmdByte, CharNl);
		end
	endtask

	task automatic drain_responses();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	initial begin
		cycles = 0;
		while (cycles < CycleLimit) begin
			@(posedge clk);
			cycles++;
		end
		$display("at_modem_response_parser test failed");
		$finish;
	end

	initial begin
		int         kind;
		int         n;
		int         len;
		int         eff;
		int         variant;
		logic [7:0] lc;
		logic [7:0] c;
		string      digits;
		string      s;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text("OK", 1'b1);
		push_beat(CmdSend, 8'hFF);
		push_beat(CmdByte, CharPrompt);
		send_text("+IPD,4,2:", 1'b0);
		push_beat(CmdByte, 8'h00);
		push_beat(CmdSend, 8'h00);
		push_beat(CmdByte, 8'hFF);
		push_beat(CmdByte, CharNl);
		drain_responses();

		while (items_sent < Items) begin
			if ($urandom_range(0, 7) == 0)
				calm = ~calm;
			if ($urandom_range(0, 39) == 0)
				drain_responses();
			kind = $urandom_range(0, 99);
			if (kind < 10) begin
				case ($urandom_range(0, 4))
				0: send_text("OK", 1'b1);
				1: send_text("ERROR", 1'b1);
				2: send_text("SEND OK", 1'b1);
				3: send_text("SEND FAIL", 1'b1);
				default: send_text("ready", 1'b1);
				endcase
			end else if (kind < 15) begin
				case ($urandom_range(0, 6))
				0: push_beat(CmdByte, CharNl);
				1: send_text("", 1'b1);
				2: send_text(" ", 1'b1);
				3: send_text("ATE0", 1'b1);
				4: send_text($sformatf("%c%c", text_char(), text_char()), 1'b1);
				5: send_text($sformatf("Recv %0d bytes", $urandom_range(1, 2048)), 1'b1);
				default: send_text($sformatf("id:%0d", $urandom_range(0, 99)), 1'b1);
				endcase
			end else if (kind < 30) begin
				n = $urandom_range(0, 9);
				if (n < 7) begin
					push_beat(CmdByte, Char0 + 8'($urandom_range(0, 6)));
					push_beat(CmdByte, CharComma);
				end else if (n < 9) begin
					c = 8'($urandom);
					if (c == CharNl || c == CharPrompt)
						c = CharSpace;
					push_beat(CmdByte, c);
				end
				if ($urandom_range(0, 1))
					send_text("CONNECT", 1'b1);
				else
					send_text("CLOSED", 1'b1);
			end else if (kind < 55) begin
				n = $urandom_range(0, 99);
				if (n < 85)
					lc = Char0 + 8'($urandom_range(0, 4));
				else if (n < 95)
					lc = Char0 + 8'($urandom_range(5, 9));
				else
					lc = 8'($urandom);
				if (lc == 8'h00 || lc == CharNl || lc == CharPrompt || lc == CharComma
						|| lc == CharColon)
					lc = 8'hA5;
				n = $urandom_range(0, 99);
				if (n < 70)
					len = $urandom_range(0, 16);
				else if (n < 88)
					len = $urandom_range(17, 64);
				else if (n < 97)
					len = $urandom_range(65, 300);
				else
					len = $urandom_range(2000, 9999);
				digits = $urandom_range(0, 9) == 0 ? $sformatf("%05d", len)
					: $sformatf("%0d", len);
				eff = len > PayloadMax ? PayloadMax : len;
				variant = $urandom_range(0, 9);
				send_text("+IPD", 1'b0);
				case (variant)
				0: begin
					send_text($sformatf(",%c:", lc), 1'b0);
					eff = 0;
				end
				1: begin
					send_text(":", 1'b0);
					eff = 0;
				end
				2: send_text($sformatf(",%c%c,%s:", text_char(), lc, digits), 1'b0);
				3: send_text($sformatf(",%c,%s,%0d:", lc, digits, $urandom_range(0, 99)),
					1'b0);
				4: send_text($sformatf(",%c,%s%s9:", lc, digits,
					$urandom_range(0, 1) ? " " : "-"), 1'b0);
				5: begin
					send_text($sformatf(",%c", lc), 1'b1);
					eff = 0;
				end
				default: send_text($sformatf(",%c,%s:", lc, digits), 1'b0);
				endcase
				n = $urandom_range(0, 9);
				if (n == 0)
					eff = eff + $urandom_range(1, 3);
				else if (n == 1 && eff > 0)
					eff = eff - 1;
				if (eff > Items - items_sent)
					eff = Items - items_sent;
				for (int k = 0; k < eff; k++) begin
					if ($urandom_range(0, 29) == 0)
						push_beat(CmdSend, 8'($urandom));
					push_beat(CmdByte, 8'($urandom));
				end
			end else if (kind < 63) begin
				case ($urandom_range(0, 2))
				0: push_beat(CmdSend, 8'($urandom));
				1: begin
					push_beat(CmdSend, 8'($urandom));
					if ($urandom_range(0, 1))
						send_text("SEND OK", 1'b1);
					else
						send_text("SEND FAIL", 1'b1);
				end
				default: begin
					send_text("OK", 1'b0);
					push_beat(CmdSend, 8'($urandom));
					send_text("", 1'b1);
				end
				endcase
			end else if (kind < 67) begin
				repeat ($urandom_range(0, 5)) push_beat(CmdByte, text_char());
				push_beat(CmdByte, CharPrompt);
			end else if (kind < 70) begin
				n = $urandom_range(LineMax - 2, LineMax);
				repeat (n) push_beat(CmdByte, text_char());
				if (n < LineMax)
					push_beat(CmdByte, CharNl);
			end else if (kind < 85) begin
				repeat ($urandom_range(1, 12)) push_beat(CmdByte, 8'($urandom));
				if ($urandom_range(0, 1))
					send_text("", 1'b1);
			end else begin
				case ($urandom_range(0, 5))
				0: s = "OK ";
				1: s = "ERRORS";
				2: s = "SEND OKAY";
				3: s = "ready!";
				default: begin
					s = "";
					repeat ($urandom_range(0, 14)) s = $sformatf("%s%c", s, text_char());
				end
				endcase
				send_text(s, 1'b1);
			end
		end

		drain_responses();
		repeat (10) @(posedge clk);
		if (failures == 0 && outstanding == 0)
			$display("at_modem_response_parser test passed");
		else
			$display("at_modem_response_parser test failed");
		$finish;
	end

endmodule
